FILE: rtl/core/jcrls_pkg.sv
// Shared types and constants for the JPEG coefficient run-length symbolizer.
// No dependencies; every module of the block imports this package.
`default_nettype none

package jcrls_pkg;

	localparam int BLOCK_COEFFICIENTS = 64;
	localparam int POS_W  = $clog2(BLOCK_COEFFICIENTS);
	localparam int COEF_W = 16;
	localparam int AMP_W  = 15;
	localparam int SIZE_W = 4;
	localparam int SYM_W  = 8;
	localparam int RUN_W  = 4;
	localparam int ZRL_W  = 2;
	localparam int CNT_W  = 3;

	localparam logic [POS_W-1:0]  LAST_POS        = POS_W'(BLOCK_COEFFICIENTS - 1);
	localparam logic [SYM_W-1:0]  ZERO_RUN_SYMBOL = 8'hF0;
	localparam logic [SYM_W-1:0]  EOB_SYMBOL      = 8'h00;
	localparam logic [COEF_W-1:0] COEF_MOST_NEG   = 16'h8000;
	localparam logic              CLASS_DC        = 1'b0;
	localparam logic              CLASS_AC        = 1'b1;

	// Kind of result sent for a given slot of an item's result list.
	typedef enum logic [1:0] {
		KIND_ZRL   = 2'd0,
		KIND_CODED = 2'd1,
		KIND_EOB   = 2'd2
	} kind_t;

	// Size category and amplitude bits of one coefficient.
	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [AMP_W-1:0]  bits;
	} amp_t;

	// Result list of the item held in stage 1.
	typedef struct packed {
		logic              dc;
		logic              coded;
		logic [ZRL_W-1:0]  zrl;
		logic              eob;
		logic [RUN_W-1:0]  run;
		logic [CNT_W-1:0]  count;
	} plan_t;

endpackage

`default_nettype wire

FILE: rtl/core/jcrls_amplitude.sv
// Size category and amplitude bits of one coefficient, with saturation.
// Combinational; uses jcrls_pkg.
`default_nettype none

module jcrls_amplitude
	import jcrls_pkg::*;
(
	input  wire logic [COEF_W-1:0] coef,
	output amp_t                   amp
);

	logic [COEF_W-1:0] sat;
	logic [AMP_W-1:0]  mag;
	logic [AMP_W-1:0]  mask;
	logic [SIZE_W-1:0] size;

	always_comb begin
		sat = (coef == COEF_MOST_NEG) ? (COEF_MOST_NEG + COEF_W'(1)) : coef;
		mag = sat[COEF_W-1] ? AMP_W'(-sat) : sat[AMP_W-1:0];
		size = '0;
		for (int i = 0; i < AMP_W; i++) begin
			if (mag[i]) size = SIZE_W'(i + 1);
		end
		mask = '0;
		for (int i = 0; i < AMP_W; i++) begin
			mask[i] = (SIZE_W'(i) < size);
		end
		// A negative value minus one is the complement of its magnitude.
		amp.size = size;
		amp.bits = (sat[COEF_W-1] ? ~mag : mag) & mask;
	end

endmodule

`default_nettype wire

FILE: rtl/core/jcrls_input_stage.sv
// Stage 1 coefficient register, block position state and the result list plan.
// Uses jcrls_pkg and jcrls_amplitude.
`default_nettype none

module jcrls_input_stage
	import jcrls_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [COEF_W-1:0] coefficient,
	input  wire logic              retire,
	output logic                   valid_s1,
	output plan_t                  plan,
	output amp_t                   amp
);

	logic [COEF_W-1:0] coef_s1;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  last_q;
	logic              pos0;
	logic              nonzero;
	logic [POS_W-1:0]  gap_m1;

	assign in_ready = !valid_s1 || retire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (retire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) coef_s1 <= coefficient;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			last_q <= '0;
		end else if (retire) begin
			pos_q <= pos_q + POS_W'(1);
			if (pos0 || nonzero) last_q <= pos_q;
		end
	end

	jcrls_amplitude u_amp (
		.coef (coef_s1),
		.amp  (amp)
	);

	always_comb begin
		pos0    = (pos_q == '0);
		nonzero = (coef_s1 != '0);
		gap_m1  = pos_q - last_q - POS_W'(1);
		plan.dc    = pos0;
		plan.coded = pos0 || nonzero;
		// Each full span of 16 skipped zeros costs one zero-run symbol.
		plan.zrl   = (!pos0 && nonzero) ? gap_m1[POS_W-1:RUN_W] : '0;
		plan.run   = gap_m1[RUN_W-1:0];
		plan.eob   = !pos0 && (pos_q == LAST_POS) && !nonzero;
		plan.count = CNT_W'(plan.zrl) + CNT_W'(plan.coded) + CNT_W'(plan.eob);
	end

endmodule

`default_nettype wire

FILE: rtl/core/jcrls_emitter.sv
// Walks the result list of the stage 1 item and loads the output register.
// Uses jcrls_pkg.
`default_nettype none

module jcrls_emitter
	import jcrls_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              valid_s1,
	input  wire plan_t             plan,
	input  wire amp_t              amp,
	output logic                   retire,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   symbol_class,
	output logic [SYM_W-1:0]       symbol,
	output logic [SIZE_W-1:0]      extra_bit_count,
	output logic [AMP_W-1:0]       extra_bits,
	output logic                   last_of_run
);

	logic [ZRL_W-1:0] idx_q;
	logic             fire;
	logic             is_last;
	kind_t            kind;

	assign fire    = valid_s1 && (plan.count != '0) && (!out_valid || out_ready);
	assign is_last = (CNT_W'(idx_q) == plan.count - CNT_W'(1));
	// An item with no results leaves stage 1 at once.
	assign retire  = valid_s1 && ((plan.count == '0) || (fire && is_last));

	always_comb begin
		if (CNT_W'(idx_q) < CNT_W'(plan.zrl)) begin
			kind = KIND_ZRL;
		end else if (plan.coded && (idx_q == plan.zrl)) begin
			kind = KIND_CODED;
		end else begin
			kind = KIND_EOB;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (retire) begin
				idx_q <= '0;
			end else if (fire) begin
				idx_q <= idx_q + ZRL_W'(1);
			end
			if (fire) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			last_of_run <= is_last;
			case (kind)
				KIND_CODED: begin
					symbol_class    <= plan.dc ? CLASS_DC : CLASS_AC;
					symbol          <= plan.dc ? SYM_W'(amp.size) : {plan.run, amp.size};
					extra_bit_count <= amp.size;
					extra_bits      <= amp.bits;
				end
				KIND_ZRL: begin
					symbol_class    <= CLASS_AC;
					symbol          <= ZERO_RUN_SYMBOL;
					extra_bit_count <= '0;
					extra_bits      <= '0;
				end
				default: begin
					symbol_class    <= CLASS_AC;
					symbol          <= EOB_SYMBOL;
					extra_bit_count <= '0;
					extra_bits      <= '0;
				end
			endcase
		end
	end

	a_idx_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (plan.count != '0) |-> CNT_W'(idx_q) < plan.count)
		else $error("result index ran past the item's result list");

	a_idx_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		retire |=> idx_q == '0)
		else $error("result index not cleared after the item left stage 1");

	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> idx_q == '0)
		else $error("result index nonzero with stage 1 empty");

	a_dc_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && plan.dc |-> plan.count == CNT_W'(1))
		else $error("DC item must give exactly one result");

endmodule

`default_nettype wire

FILE: rtl/core/jpeg_coefficient_run_length_symbolizer.sv
// Top level of the JPEG coefficient run-length symbolizer.
// Uses jcrls_pkg, jcrls_input_stage and jcrls_emitter.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_ready  | coefficient
//  output   | out_valid / out_ready| symbol_class, symbol, extra_bit_count,
//           |                      | extra_bits, last_of_run
//
// An item is registered in stage 1 and its results leave through the output
// register. One item per cycle while each item gives at most one result and
// the output does not stall; an item with k results (up to four: three
// zero-run symbols and a coded symbol) holds stage 1 until its last result
// is sent, as the result port is single. An AC zero with no result still
// enters stage 1. Reset clears the block position to the start of a block;
// no clearing pass. Output stalls back up into stage 1 and then into in_ready.
`default_nettype none

module jpeg_coefficient_run_length_symbolizer
	import jcrls_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [COEF_W-1:0] coefficient,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   symbol_class,
	output logic [SYM_W-1:0]       symbol,
	output logic [SIZE_W-1:0]      extra_bit_count,
	output logic [AMP_W-1:0]       extra_bits,
	output logic                   last_of_run
);

	logic  retire;
	logic  valid_s1;
	plan_t plan;
	amp_t  amp;

	jcrls_input_stage u_input (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.coefficient (coefficient),
		.retire      (retire),
		.valid_s1    (valid_s1),
		.plan        (plan),
		.amp         (amp)
	);

	jcrls_emitter u_emit (
		.clk             (clk),
		.arst_n          (arst_n),
		.valid_s1        (valid_s1),
		.plan            (plan),
		.amp             (amp),
		.retire          (retire),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.symbol_class    (symbol_class),
		.symbol          (symbol),
		.extra_bit_count (extra_bit_count),
		.extra_bits      (extra_bits),
		.last_of_run     (last_of_run)
	);

endmodule

`default_nettype wire

FILE: verif/tb_jpeg_coefficient_run_length_symbolizer.sv
// Self-checking testbench for jpeg_coefficient_run_length_symbolizer.
// Depends on jcrls_pkg and the block RTL; a directed table and random blocks are
// checked against an in-bench symbol predictor.
`default_nettype none

module tb_jpeg_coefficient_run_length_symbolizer;
	import jcrls_pkg::*;

	localparam int RUN_SPAN   = 16;
	localparam int LONG_HOLD  = 200;
	localparam int RAND_ITEMS = 214;
	localparam int ROWS       = 20;

	typedef struct packed {
		logic              table_ac;
		logic [SYM_W-1:0]  code;
		logic [SIZE_W-1:0] amp_len;
		logic [AMP_W-1:0]  amp;
		logic              closes_item;
	} coded_symbol_t;

	typedef struct packed {
		logic [POS_W-1:0]  pos;
		logic [COEF_W-1:0] coef;
		logic              typed;
		coded_symbol_t     want;
	} stim_row_t;

	typedef enum logic [1:0] {
		RX_STEADY,
		RX_COIN,
		RX_EVERY_THIRD
	} rx_mode_t;

	// Rows are placed by position; the gaps in between are filled with zeros.
	localparam stim_row_t STIM_ROWS [ROWS] = '{
		'{6'd0,  16'h7FFF, 1'b1, '{CLASS_DC, 8'h0F, 4'd15, 15'h7FFF, 1'b1}},
		'{6'd1,  16'h8000, 1'b1, '{CLASS_AC, 8'h0F, 4'd15, 15'h0000, 1'b1}},
		'{6'd2,  16'h0001, 1'b1, '{CLASS_AC, 8'h01, 4'd1,  15'h0001, 1'b1}},
		'{6'd3,  16'hFFFF, 1'b1, '{CLASS_AC, 8'h01, 4'd1,  15'h0000, 1'b1}},
		'{6'd5,  16'h0002, 1'b0, '0},
		'{6'd22, 16'hFFFD, 1'b0, '0},
		'{6'd40, 16'h4000, 1'b0, '0},
		'{6'd63, 16'h0000, 1'b1, '{CLASS_AC, EOB_SYMBOL, 4'd0, 15'h0000, 1'b1}},
		'{6'd0,  16'h0000, 1'b1, '{CLASS_DC, 8'h00, 4'd0,  15'h0000, 1'b1}},
		'{6'd63, 16'h0005, 1'b0, '0},
		'{6'd0,  16'h8000, 1'b1, '{CLASS_DC, 8'h0F, 4'd15, 15'h0000, 1'b1}},
		'{6'd1,  16'h5555, 1'b0, '0},
		'{6'd2,  16'hAAAB, 1'b0, '0},
		'{6'd17, 16'h0007, 1'b0, '0},
		'{6'd34, 16'hFFF9, 1'b0, '0},
		'{6'd50, 16'h0064, 1'b0, '0},
		'{6'd62, 16'h0001, 1'b0, '0},
		'{6'd63, 16'h0000, 1'b1, '{CLASS_AC, EOB_SYMBOL, 4'd0, 15'h0000, 1'b1}},
		'{6'd0,  16'h0001, 1'b1, '{CLASS_DC, 8'h01, 4'd1,  15'h0001, 1'b1}},
		'{6'd63, 16'h7FFF, 1'b0, '0}
	};

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [COEF_W-1:0] coefficient;
	logic              out_valid;
	logic              out_ready;
	logic              symbol_class;
	logic [SYM_W-1:0]  symbol;
	logic [SIZE_W-1:0] extra_bit_count;
	logic [AMP_W-1:0]  extra_bits;
	logic              last_of_run;

	coded_symbol_t pending_symbols [$];
	coded_symbol_t item_symbols [$];
	coded_symbol_t oldest;
	int            next_position;
	int            last_coded_position;
	int            mismatches;
	int            burst_left;
	bit            hold_request;

	jpeg_coefficient_run_length_symbolizer dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.coefficient     (coefficient),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.symbol_class    (symbol_class),
		.symbol          (symbol),
		.extra_bit_count (extra_bit_count),
		.extra_bits      (extra_bits),
		.last_of_run     (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic void append_symbol(input logic ac, input int code, input int len,
			input int amp);
		coded_symbol_t s;
		s.table_ac    = ac;
		s.code        = SYM_W'(code);
		s.amp_len     = SIZE_W'(len);
		s.amp         = AMP_W'(amp);
		s.closes_item = 1'b0;
		item_symbols.push_back(s);
	endfunction

	// Advances the block position and lists the symbols one coefficient produces.
	function automatic void symbolize_coefficient(input logic [COEF_W-1:0] c);
		int v;
		int mag;
		int size;
		int amp;
		int pos;
		int last;
		v = int'($signed(c));
		if (v < -32767)
			v = -32767;
		mag = (v < 0) ? -v : v;
		size = 0;
		while (size < 15 && (mag >> size) != 0)
			size++;
		amp = ((v < 0) ? v - 1 : v) & ((1 << size) - 1);
		pos = next_position;
		last = last_coded_position;
		item_symbols.delete();
		if (pos == 0) begin
			append_symbol(CLASS_DC, size, size, amp);
			last = 0;
		end else begin
			if (v != 0) begin
				while (last < pos && pos - last > RUN_SPAN) begin
					append_symbol(CLASS_AC, ZERO_RUN_SYMBOL, 0, 0);
					last += RUN_SPAN;
				end
				append_symbol(CLASS_AC, (((pos - last - 1) & 15) << 4) + size, size, amp);
				last = pos;
			end
			if (pos == int'(LAST_POS) && last != int'(LAST_POS))
				append_symbol(CLASS_AC, EOB_SYMBOL, 0, 0);
		end
		if (item_symbols.size() > 0)
			item_symbols[item_symbols.size() - 1].closes_item = 1'b1;
		last_coded_position = last & (BLOCK_COEFFICIENTS - 1);
		next_position = (pos + 1) & (BLOCK_COEFFICIENTS - 1);
	endfunction

	function automatic logic [COEF_W-1:0] random_coefficient(input int zero_pct);
		int s;
		int mag;
		if ($urandom_range(0, 99) < zero_pct)
			return '0;
		if ($urandom_range(0, 40) == 0)
			return COEF_MOST_NEG;
		s = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : $urandom_range(1, 5);
		mag = $urandom_range((1 << s) - 1, 1 << (s - 1));
		return $urandom_range(0, 1) ? COEF_W'(-mag) : COEF_W'(mag);
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(input logic [COEF_W-1:0] c, input logic typed,
			input coded_symbol_t want);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 7);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		coefficient <= c;
		do @(posedge clk); while (!in_ready);
		symbolize_coefficient(c);
		if (typed)
			pending_symbols.push_back(want);
		else
			foreach (item_symbols[k])
				pending_symbols.push_back(item_symbols[k]);
		@(negedge clk);
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_symbols.size() != 0);
	endtask

	// Receiver: switches among stall patterns and honors a requested long hold.
	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       phase;
		out_ready = 1'b0;
		mode = RX_STEADY;
		mode_left = 0;
		phase = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_request = 1'b0;
			end
			if (mode_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(16, 80);
			end
			mode_left--;
			phase++;
			case (mode)
				RX_STEADY:      out_ready <= 1'b1;
				RX_COIN:        out_ready <= 1'($urandom_range(0, 1));
				default:        out_ready <= (phase % 3 == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_symbols.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual %0h/%0h/%0h/%0h/%0h",
					$time, symbol_class, symbol, extra_bit_count, extra_bits, last_of_run);
			end else begin
				oldest = pending_symbols.pop_front();
				check_field("symbol_class", oldest.table_ac, symbol_class);
				check_field("symbol", oldest.code, symbol);
				check_field("extra_bit_count", oldest.amp_len, extra_bit_count);
				check_field("extra_bits", oldest.amp, extra_bits);
				check_field("last_of_run", oldest.closes_item, last_of_run);
			end
		end
	end

	initial begin
		int zero_pct;
		arst_n = 1'b0;
		in_valid = 1'b0;
		coefficient = '0;
		hold_request = 1'b0;
		mismatches = 0;
		burst_left = 0;
		next_position = 0;
		last_coded_position = 0;
		zero_pct = 50;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int r = 0; r < ROWS; r++) begin
			while (next_position != int'(STIM_ROWS[r].pos))
				send_item('0, 1'b0, '0);
			send_item(STIM_ROWS[r].coef, STIM_ROWS[r].typed, STIM_ROWS[r].want);
		end
		wait_for_drain();

		for (int i = 0; i < RAND_ITEMS; i++) begin
			// The sender keeps offering items while the receiver holds off.
			if (i == 60)
				hold_request = 1'b1;
			if (i == 150)
				wait_for_drain();
			if (next_position == 0) begin
				case ($urandom_range(0, 5))
					0:       zero_pct = 100;
					1:       zero_pct = 98;
					2:       zero_pct = 85;
					default: zero_pct = $urandom_range(0, 70);
				endcase
			end
			send_item(random_coefficient(zero_pct), 1'b0, '0);
		end

		wait_for_drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_symbols.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/jcrls_pkg.sv
rtl/core/jcrls_amplitude.sv
rtl/core/jcrls_input_stage.sv
rtl/core/jcrls_emitter.sv
rtl/core/jpeg_coefficient_run_length_symbolizer.sv
verif/tb_jpeg_coefficient_run_length_symbolizer.sv
